// ----- sv/apfe_pkg.sv -----
`default_nettype none

package apfe_pkg;

    // defaults for the top-level parameters
    localparam int SITE_COUNT_BITS_DEF = 16;
    localparam int TOTAL_BITS_DEF      = 40;
    localparam int FRACTION_BITS_DEF   = 16;

    localparam logic [15:0] MIN_DEPTH_RESET = 16'd10;

    // stream widths
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 312;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = 2;
    localparam int CNT_OUT_W   = 40;
    localparam int FRAC_OUT_W  = 18;

    // input tuser bit positions
    localparam int TU_HAS_READ  = 0;
    localparam int TU_DUPLICATE = 1;
    localparam int TU_BATCH_END = 2;

    localparam logic [7:0] BASE_A = 8'h41;
    localparam logic [7:0] BASE_C = 8'h43;
    localparam logic [7:0] BASE_G = 8'h47;
    localparam logic [7:0] BASE_T = 8'h54;

    typedef enum logic [1:0] {
        KIND_FAIL    = 2'd0,
        KIND_PASS    = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        DIV_SITE_A = 2'd0,
        DIV_SITE_B = 2'd1,
        DIV_SUM_B  = 2'd2,
        DIV_SUM_C  = 2'd3
    } t_div_op;

    typedef struct packed {
        logic    div_start;
        t_div_op div_op;
        logic    load_site;
        logic    load_sum;
    } t_cmd;

    typedef struct packed {
        logic in_site_end;
        logic in_batch_end;
        logic batch_end_q;
        logic site_div_ok;
        logic site_adj_ok;
        logic sum_div_ok;
        logic sum_adj_ok;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/apfe_div.sv -----
`default_nettype none

module apfe_div #(
    parameter int DW  = 40,
    parameter int QW  = 18,
    parameter int STW = 5
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DW-1:0]  i_hi,
    input  wire logic           i_extra,
    input  wire logic [DW-1:0]  i_den,
    input  wire logic [STW-1:0] i_steps,
    output logic                o_done,
    output logic [QW-1:0]       o_quot
);
    import apfe_pkg::*;

    logic           r_busy;
    logic           r_done;
    logic           r_first;
    logic           r_extra;
    logic [STW-1:0] r_cnt;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [QW-1:0]  r_quot;

    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;

    // the half bit of the numerator enters on the first step only
    always_comb begin
        trial = {r_rem, 1'b0} | {{DW{1'b0}}, (r_first & r_extra)};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STW'(1);
                if (r_cnt == STW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_first <= 1'b1;
            r_extra <= i_extra;
            r_den   <= i_den;
            // whole part is 0 or 1 since the numerator never exceeds the divisor
            if (i_hi >= i_den) begin
                r_rem  <= i_hi - i_den;
                r_quot <= QW'(1);
            end else begin
                r_rem  <= i_hi;
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_first <= 1'b0;
            r_quot  <= {r_quot[QW-2:0], ge};
            r_rem   <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- sv/apfe_ctrl.sv -----
`default_nettype none

module apfe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire apfe_pkg::t_status i_st,
    output apfe_pkg::t_cmd         o_cmd,
    output logic                   o_s_tready
);
    import apfe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SITE_CHK,
        S_SITE_A,
        S_SITE_B,
        S_SITE_OUT,
        S_SITE_POST,
        S_SUM_CHK,
        S_SUM_C,
        S_SUM_B,
        S_SUM_OUT,
        S_SUM_POST
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_cmd   <= '0;
        end else begin
            r_cmd <= '0;
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && r_ready) begin
                        if (i_st.in_site_end) begin
                            r_state <= S_SITE_CHK;
                            r_ready <= 1'b0;
                        end else if (i_st.in_batch_end) begin
                            r_state <= S_SUM_CHK;
                            r_ready <= 1'b0;
                        end
                    end
                end
                S_SITE_CHK: begin
                    if (i_st.site_div_ok) begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_op    <= DIV_SITE_A;
                        r_state         <= S_SITE_A;
                    end else begin
                        r_state <= S_SITE_OUT;
                    end
                end
                S_SITE_A: begin
                    if (i_st.div_done) begin
                        if (i_st.site_adj_ok) begin
                            r_cmd.div_start <= 1'b1;
                            r_cmd.div_op    <= DIV_SITE_B;
                            r_state         <= S_SITE_B;
                        end else begin
                            r_state <= S_SITE_OUT;
                        end
                    end
                end
                S_SITE_B: begin
                    if (i_st.div_done) begin
                        r_state <= S_SITE_OUT;
                    end
                end
                S_SITE_OUT: begin
                    // a free output register stays free until our own load
                    if (i_st.out_free) begin
                        r_cmd.load_site <= 1'b1;
                        r_state         <= S_SITE_POST;
                    end
                end
                S_SITE_POST: begin
                    if (i_st.batch_end_q) begin
                        r_state <= S_SUM_CHK;
                    end else begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                S_SUM_CHK: begin
                    if (i_st.sum_div_ok) begin
                        r_cmd.div_start <= 1'b1;
                        r_cmd.div_op    <= DIV_SUM_C;
                        r_state         <= S_SUM_C;
                    end else begin
                        r_state <= S_SUM_OUT;
                    end
                end
                S_SUM_C: begin
                    if (i_st.div_done) begin
                        if (i_st.sum_adj_ok) begin
                            r_cmd.div_start <= 1'b1;
                            r_cmd.div_op    <= DIV_SUM_B;
                            r_state         <= S_SUM_B;
                        end else begin
                            r_state <= S_SUM_OUT;
                        end
                    end
                end
                S_SUM_B: begin
                    if (i_st.div_done) begin
                        r_state <= S_SUM_OUT;
                    end
                end
                S_SUM_OUT: begin
                    if (i_st.out_free) begin
                        r_cmd.load_sum <= 1'b1;
                        r_state        <= S_SUM_POST;
                    end
                end
                S_SUM_POST: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_cmd      = r_cmd;
    assign o_s_tready = r_ready;

endmodule

`default_nettype wire

// ----- sv/apfe_dp.sv -----
`default_nettype none

module apfe_dp #(
    parameter int SITE_COUNT_BITS = apfe_pkg::SITE_COUNT_BITS_DEF,
    parameter int TOTAL_BITS      = apfe_pkg::TOTAL_BITS_DEF,
    parameter int FRACTION_BITS   = apfe_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire logic [apfe_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                               i_s_tlast,
    input  wire logic [apfe_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [15:0]                        i_cfg_wr_data,
    input  wire apfe_pkg::t_cmd                     i_cmd,
    output apfe_pkg::t_status                       o_st,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [apfe_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic                                    o_m_tlast,
    output logic [apfe_pkg::OUT_TUSER_W-1:0]        o_m_tuser
);
    import apfe_pkg::*;

    localparam int CW  = SITE_COUNT_BITS;
    localparam int DPW = SITE_COUNT_BITS + 2;
    localparam int TW  = TOTAL_BITS;
    localparam int DW  = (TW > DPW) ? TW : DPW;
    localparam int SW  = DW + 1;
    localparam int MW  = (DPW > 16) ? DPW : 16;
    localparam int QW  = FRACTION_BITS + 2;
    localparam int STW = $clog2(FRACTION_BITS + 2);
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    // input unpacking
    logic [31:0] in_site_id;
    logic [7:0]  in_ref, in_alt, in_min_mq, in_min_bq, in_mq, in_bq, in_obs;
    logic        in_has_read, in_dup, in_batch_end;
    logic        read_ok;

    assign in_site_id   = i_s_tdata[31:0];
    assign in_ref       = i_s_tdata[39:32];
    assign in_alt       = i_s_tdata[47:40];
    assign in_min_mq    = i_s_tdata[55:48];
    assign in_min_bq    = i_s_tdata[63:56];
    assign in_mq        = i_s_tdata[71:64];
    assign in_bq        = i_s_tdata[79:72];
    assign in_obs       = i_s_tdata[87:80];
    assign in_has_read  = i_s_tuser[TU_HAS_READ];
    assign in_dup       = i_s_tuser[TU_DUPLICATE];
    assign in_batch_end = i_s_tuser[TU_BATCH_END];

    assign read_ok = in_has_read && !in_dup && (in_mq >= in_min_mq) && (in_bq >= in_min_bq);

    logic [15:0] r_min_depth;
    logic [31:0] r_site_id;
    logic        r_batch_end;
    logic [CW-1:0] r_ref, r_alt, r_oth;
    logic [TW-1:0] r_sum_ref, r_sum_alt, r_sum_oth, r_sum_dep;
    logic [31:0]   r_tally_all, r_tally_pass, r_tally_det;
    logic [QW-1:0] r_frac_a, r_frac_b, r_frac_c;
    t_div_op       r_div_op;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [31:0]       r_out_ident, r_out_pass, r_out_det;
    logic [CNT_OUT_W-1:0]  r_out_ref, r_out_alt, r_out_oth, r_out_dep;
    logic [FRAC_OUT_W-1:0] r_out_fa, r_out_fb, r_out_fc;
    logic              r_out_last;

    // site figures
    logic [DPW-1:0] site_dep;
    logic           site_pass;
    logic           site_adj_ok;
    logic [CW-1:0]  site_k;
    logic           sum_adj_ok;
    logic [TW-1:0]  sum_k;

    always_comb begin
        site_dep    = DPW'(r_ref) + DPW'(r_alt) + DPW'(r_oth);
        site_pass   = MW'(site_dep) >= MW'(r_min_depth);
        // alt - other/2 split into whole part and half bit
        site_adj_ok = r_alt > (r_oth >> 1);
        site_k      = r_alt - (r_oth >> 1) - CW'(r_oth[0]);
        sum_adj_ok  = r_sum_alt > (r_sum_oth >> 1);
        sum_k       = r_sum_alt - (r_sum_oth >> 1) - TW'(r_sum_oth[0]);
    end

    function automatic logic [TW-1:0] f_sat_add(input logic [TW-1:0] a,
                                                input logic [DPW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(TMAX)) ? TMAX : s[TW-1:0];
    endfunction

    // divider operand select
    logic [DW-1:0]  div_hi, div_den;
    logic           div_extra;
    logic [STW-1:0] div_steps;
    logic           div_done;
    logic [QW-1:0]  div_quot;

    always_comb begin
        case (i_cmd.div_op)
            DIV_SITE_A: begin
                div_hi    = DW'(r_alt);
                div_extra = 1'b0;
                div_den   = DW'(site_dep);
                div_steps = STW'(FRACTION_BITS);
            end
            DIV_SITE_B: begin
                div_hi    = DW'(site_k);
                div_extra = r_oth[0];
                div_den   = DW'(site_dep);
                div_steps = STW'(FRACTION_BITS);
            end
            DIV_SUM_B: begin
                div_hi    = DW'(sum_k);
                div_extra = r_sum_oth[0];
                div_den   = DW'(r_sum_dep);
                div_steps = STW'(FRACTION_BITS + 1);
            end
            DIV_SUM_C: begin
                div_hi    = DW'(r_sum_oth);
                div_extra = 1'b0;
                div_den   = DW'(r_sum_dep);
                div_steps = STW'(FRACTION_BITS - 1);
            end
            default: begin
                div_hi    = '0;
                div_extra = 1'b0;
                div_den   = '0;
                div_steps = '0;
            end
        endcase
    end

    apfe_div #(
        .DW  (DW),
        .QW  (QW),
        .STW (STW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_hi    (div_hi),
        .i_extra (div_extra),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration and per-site counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth <= MIN_DEPTH_RESET;
            r_ref       <= '0;
            r_alt       <= '0;
            r_oth       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_depth <= i_cfg_wr_data;
            end
            if (i_cmd.load_site) begin
                r_ref <= '0;
                r_alt <= '0;
                r_oth <= '0;
            end else if (i_accept && read_ok) begin
                if (in_obs == in_ref) begin
                    r_ref <= (r_ref == '1) ? r_ref : r_ref + CW'(1);
                end else if (in_obs == in_alt) begin
                    r_alt <= (r_alt == '1) ? r_alt : r_alt + CW'(1);
                end else if (in_obs == BASE_A || in_obs == BASE_C ||
                             in_obs == BASE_G || in_obs == BASE_T) begin
                    r_oth <= (r_oth == '1) ? r_oth : r_oth + CW'(1);
                end
            end
        end
    end

    // batch sums and tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_ref    <= '0;
            r_sum_alt    <= '0;
            r_sum_oth    <= '0;
            r_sum_dep    <= '0;
            r_tally_all  <= '0;
            r_tally_pass <= '0;
            r_tally_det  <= '0;
        end else if (i_cmd.load_sum) begin
            r_sum_ref    <= '0;
            r_sum_alt    <= '0;
            r_sum_oth    <= '0;
            r_sum_dep    <= '0;
            r_tally_all  <= '0;
            r_tally_pass <= '0;
            r_tally_det  <= '0;
        end else if (i_cmd.load_site) begin
            r_tally_all <= (r_tally_all == '1) ? r_tally_all : r_tally_all + 32'd1;
            if (site_pass) begin
                r_tally_pass <= (r_tally_pass == '1) ? r_tally_pass : r_tally_pass + 32'd1;
                if (r_alt != '0) begin
                    r_tally_det <= (r_tally_det == '1) ? r_tally_det : r_tally_det + 32'd1;
                end
                r_sum_ref <= f_sat_add(r_sum_ref, DPW'(r_ref));
                r_sum_alt <= f_sat_add(r_sum_alt, DPW'(r_alt));
                r_sum_oth <= f_sat_add(r_sum_oth, DPW'(r_oth));
                r_sum_dep <= f_sat_add(r_sum_dep, site_dep);
            end
        end
    end

    // item context and fractions
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_site_id   <= in_site_id;
            r_batch_end <= in_batch_end;
        end
        if (i_cmd.div_start) begin
            r_div_op <= i_cmd.div_op;
        end
        if (i_accept || i_cmd.load_site) begin
            r_frac_a <= '0;
            r_frac_b <= '0;
            r_frac_c <= '0;
        end else if (div_done) begin
            case (r_div_op)
                DIV_SITE_A: r_frac_a <= div_quot;
                DIV_SITE_B: r_frac_b <= div_quot;
                DIV_SUM_C:  r_frac_c <= div_quot;
                DIV_SUM_B: begin
                    // tumour fraction has one more bit; the mean is it halved
                    r_frac_b <= div_quot;
                    r_frac_a <= div_quot >> 1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_site || i_cmd.load_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_site) begin
            r_out_kind  <= site_pass ? KIND_PASS : KIND_FAIL;
            r_out_ident <= r_site_id;
            r_out_ref   <= CNT_OUT_W'(r_ref);
            r_out_alt   <= CNT_OUT_W'(r_alt);
            r_out_oth   <= CNT_OUT_W'(r_oth);
            r_out_dep   <= CNT_OUT_W'(site_dep);
            r_out_pass  <= '0;
            r_out_det   <= '0;
            r_out_fa    <= FRAC_OUT_W'(r_frac_a);
            r_out_fb    <= FRAC_OUT_W'(r_frac_b);
            r_out_fc    <= '0;
            r_out_last  <= !r_batch_end;
        end else if (i_cmd.load_sum) begin
            r_out_kind  <= KIND_SUMMARY;
            r_out_ident <= r_tally_all;
            r_out_ref   <= CNT_OUT_W'(r_sum_ref);
            r_out_alt   <= CNT_OUT_W'(r_sum_alt);
            r_out_oth   <= CNT_OUT_W'(r_sum_oth);
            r_out_dep   <= CNT_OUT_W'(r_sum_dep);
            r_out_pass  <= r_tally_pass;
            r_out_det   <= r_tally_det;
            r_out_fa    <= FRAC_OUT_W'(r_frac_a);
            r_out_fb    <= FRAC_OUT_W'(r_frac_b);
            r_out_fc    <= FRAC_OUT_W'(r_frac_c);
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_fc, r_out_fb, r_out_fa, r_out_det,
                         r_out_pass, r_out_dep, r_out_oth, r_out_alt, r_out_ref,
                         r_out_ident};

    always_comb begin
        o_st.in_site_end  = i_s_tlast;
        o_st.in_batch_end = in_batch_end;
        o_st.batch_end_q  = r_batch_end;
        o_st.site_div_ok  = site_pass && (site_dep != '0);
        o_st.site_adj_ok  = site_adj_ok;
        o_st.sum_div_ok   = r_sum_dep != '0;
        o_st.sum_adj_ok   = sum_adj_ok;
        o_st.div_done     = div_done;
        o_st.out_free     = !r_out_valid || i_m_tready;
    end

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_site || i_cmd.load_sum) |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken beat");

    a_no_accept_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> !(i_cmd.load_site || i_cmd.load_sum || i_cmd.div_start))
        else $error("input beat taken while a result is in flight");

    a_tally_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tally_det <= r_tally_pass) && (r_tally_pass <= r_tally_all))
        else $error("site tallies out of order");

    a_alt_in_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_alt <= r_sum_dep) && (r_sum_oth <= r_sum_dep))
        else $error("summed counts exceed summed depth");

endmodule

`default_nettype wire

// ----- sv/allele_pileup_fraction_estimator_unit.sv -----
// channel | dir | handshake            | payload
// s       | in  | i_s_tvalid/o_s_tready | tdata read beat, tlast site end, tuser flags
// m       | out | o_m_tvalid/i_m_tready | tdata counts and fractions, tlast last, tuser kind
// cfg     | in  | i_cfg_wr_en          | i_cfg_wr_data min_depth
//
// a beat that closes nothing is taken while the unit stays idle; a site close and a
// summary run their fractions through the single restoring divider, which yields one
// quotient bit a cycle for every fraction.
// reset is synchronous: counts, sums and tallies clear and min_depth returns to 10.
// one result register sits on the output; new beats are taken while it waits,
// and work stalls only when a further result is ready and the register is still full.
`default_nettype none

module allele_pileup_fraction_estimator_unit #(
    parameter int SITE_COUNT_BITS = apfe_pkg::SITE_COUNT_BITS_DEF,
    parameter int TOTAL_BITS      = apfe_pkg::TOTAL_BITS_DEF,
    parameter int FRACTION_BITS   = apfe_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [15:0]                     i_cfg_wr_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // site_id, ref_nt, alt_nt, min_mapping_quality, min_base_quality,
    // mapping_quality, base_quality, seen_nt
    input  wire logic [apfe_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  wire logic                            i_s_tlast,
    // has_read, duplicate, batch_end
    input  wire logic [apfe_pkg::IN_TUSER_W-1:0] i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // ident_or_sites, ref_total, alt_total, other_total, depth_total, pass_count,
    // detected_sites, fraction_a, fraction_b, fraction_c, zero pad
    output logic [apfe_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tlast,
    // kind
    output logic [apfe_pkg::OUT_TUSER_W-1:0]     o_m_tuser
);
    import apfe_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    s_tready;
    logic    s_accept;

    assign s_accept   = i_s_tvalid && s_tready;
    assign o_s_tready = s_tready;

    apfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_s_tready (s_tready)
    );

    apfe_dp #(
        .SITE_COUNT_BITS (SITE_COUNT_BITS),
        .TOTAL_BITS      (TOTAL_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_s_tuser     (i_s_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- sim/allele_pileup_fraction_monitor.sv -----
module allele_pileup_fraction_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [15:0]                     i_cfg_wr_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [apfe_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                            i_s_tlast,
    input  logic [apfe_pkg::IN_TUSER_W-1:0] i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [apfe_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    input  logic [apfe_pkg::OUT_TUSER_W-1:0] i_m_tuser,
    output int                              o_errors,
    output int                              o_pending
);
    import apfe_pkg::*;

    localparam int CW = SITE_COUNT_BITS_DEF;
    localparam int TW = TOTAL_BITS_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam logic [63:0] CNT_MAX   = (64'd1 << CW) - 64'd1;
    localparam logic [63:0] TOT_MAX   = (64'd1 << TW) - 64'd1;
    localparam logic [63:0] TALLY_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        t_kind                 kind;
        logic [31:0]           ident;
        logic [CNT_OUT_W-1:0]  ref_n;
        logic [CNT_OUT_W-1:0]  alt_n;
        logic [CNT_OUT_W-1:0]  oth_n;
        logic [CNT_OUT_W-1:0]  dep_n;
        logic [31:0]           passing;
        logic [31:0]           detected;
        logic [FRAC_OUT_W-1:0] frac_a;
        logic [FRAC_OUT_W-1:0] frac_b;
        logic [FRAC_OUT_W-1:0] frac_c;
        logic                  last;
    } t_result;

    logic [15:0]   depth_floor;
    logic [CW-1:0] ref_cnt, alt_cnt, oth_cnt;
    logic [TW-1:0] sum_ref, sum_alt, sum_oth, sum_dep;
    logic [31:0]   sites_seen, sites_passed, det_sites;
    t_result       expected_results[$];
    int            fail_count = 0;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] top);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, top}) ? top : s[63:0];
    endfunction

    // twice max(alt - other/2, 0), keeps the half bit
    function automatic logic [63:0] twice_adjusted(input logic [63:0] a, input logic [63:0] o);
        return ((a << 1) > o) ? (a << 1) - o : 64'd0;
    endfunction

    function automatic logic [FRAC_OUT_W-1:0] frac_q(input logic [63:0] num, input int sh,
                                                     input logic [63:0] den);
        logic [127:0] wide;
        if (den == 64'd0)
            return '0;
        wide = ({64'd0, num} << sh) / {64'd0, den};
        return wide[FRAC_OUT_W-1:0];
    endfunction

    task automatic tally_read_beat(input logic [IN_TDATA_W-1:0] d, input logic site_end,
                                   input logic [IN_TUSER_W-1:0] flags);
        logic [31:0] site_id;
        logic [7:0]  ref_b, alt_b, min_mq, min_bq, mq, bq, ob;
        logic [63:0] dep, num;
        logic        pass;
        t_result     r;
        {ob, bq, mq, min_bq, min_mq, alt_b, ref_b, site_id} = d;
        if (flags[TU_HAS_READ] && !flags[TU_DUPLICATE] && mq >= min_mq && bq >= min_bq) begin
            if (ob == ref_b)
                ref_cnt = CW'(sat_sum(64'(ref_cnt), 64'd1, CNT_MAX));
            else if (ob == alt_b)
                alt_cnt = CW'(sat_sum(64'(alt_cnt), 64'd1, CNT_MAX));
            else if (ob == BASE_A || ob == BASE_C || ob == BASE_G || ob == BASE_T)
                oth_cnt = CW'(sat_sum(64'(oth_cnt), 64'd1, CNT_MAX));
        end
        if (site_end) begin
            dep  = 64'(ref_cnt) + 64'(alt_cnt) + 64'(oth_cnt);
            pass = (dep >= 64'(depth_floor));
            r = '0;
            r.kind  = pass ? KIND_PASS : KIND_FAIL;
            r.ident = site_id;
            r.ref_n = CNT_OUT_W'(ref_cnt);
            r.alt_n = CNT_OUT_W'(alt_cnt);
            r.oth_n = CNT_OUT_W'(oth_cnt);
            r.dep_n = CNT_OUT_W'(dep);
            if (pass && dep != 64'd0) begin
                r.frac_a = frac_q(64'(alt_cnt), FB, dep);
                r.frac_b = frac_q(twice_adjusted(64'(alt_cnt), 64'(oth_cnt)), FB - 1, dep);
            end
            r.last = !flags[TU_BATCH_END];
            expected_results.insert(expected_results.size(), r);
            sites_seen = 32'(sat_sum(64'(sites_seen), 64'd1, TALLY_MAX));
            if (pass) begin
                sites_passed = 32'(sat_sum(64'(sites_passed), 64'd1, TALLY_MAX));
                if (alt_cnt != '0)
                    det_sites = 32'(sat_sum(64'(det_sites), 64'd1, TALLY_MAX));
                sum_ref = TW'(sat_sum(64'(sum_ref), 64'(ref_cnt), TOT_MAX));
                sum_alt = TW'(sat_sum(64'(sum_alt), 64'(alt_cnt), TOT_MAX));
                sum_oth = TW'(sat_sum(64'(sum_oth), 64'(oth_cnt), TOT_MAX));
                sum_dep = TW'(sat_sum(64'(sum_dep), dep, TOT_MAX));
            end
            ref_cnt = '0;
            alt_cnt = '0;
            oth_cnt = '0;
        end
        if (flags[TU_BATCH_END]) begin
            r = '0;
            r.kind     = KIND_SUMMARY;
            r.ident    = sites_seen;
            r.ref_n    = CNT_OUT_W'(sum_ref);
            r.alt_n    = CNT_OUT_W'(sum_alt);
            r.oth_n    = CNT_OUT_W'(sum_oth);
            r.dep_n    = CNT_OUT_W'(sum_dep);
            r.passing  = sites_passed;
            r.detected = det_sites;
            if (sum_dep != '0) begin
                num = twice_adjusted(64'(sum_alt), 64'(sum_oth));
                r.frac_a = frac_q(num, FB - 1, 64'(sum_dep));
                r.frac_b = frac_q(num, FB, 64'(sum_dep));
                r.frac_c = frac_q(64'(sum_oth), FB - 1, 64'(sum_dep));
            end
            r.last = 1'b1;
            expected_results.insert(expected_results.size(), r);
            sum_ref = '0;
            sum_alt = '0;
            sum_oth = '0;
            sum_dep = '0;
            sites_seen   = '0;
            sites_passed = '0;
            det_sites    = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            if (fail_count < 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result want, got;
        logic [OUT_PAD_W-1:0] pad;
        if (!i_rst_n) begin
            depth_floor = MIN_DEPTH_RESET;
            ref_cnt = '0;
            alt_cnt = '0;
            oth_cnt = '0;
            sum_ref = '0;
            sum_alt = '0;
            sum_oth = '0;
            sum_dep = '0;
            sites_seen   = '0;
            sites_passed = '0;
            det_sites    = '0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.kind = t_kind'(i_m_tuser);
                got.last = i_m_tlast;
                {pad, got.frac_c, got.frac_b, got.frac_a, got.detected, got.passing,
                 got.dep_n, got.oth_n, got.alt_n, got.ref_n, got.ident} = i_m_tdata;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected, kind %0d id %0h",
                                 $time, got.kind, got.ident);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(got.kind));
                    check_field("ident_or_sites", 64'(want.ident), 64'(got.ident));
                    check_field("ref_total", 64'(want.ref_n), 64'(got.ref_n));
                    check_field("alt_total", 64'(want.alt_n), 64'(got.alt_n));
                    check_field("other_total", 64'(want.oth_n), 64'(got.oth_n));
                    check_field("depth_total", 64'(want.dep_n), 64'(got.dep_n));
                    check_field("pass_count", 64'(want.passing), 64'(got.passing));
                    check_field("detected_sites", 64'(want.detected), 64'(got.detected));
                    check_field("fraction_a", 64'(want.frac_a), 64'(got.frac_a));
                    check_field("fraction_b", 64'(want.frac_b), 64'(got.frac_b));
                    check_field("fraction_c", 64'(want.frac_c), 64'(got.frac_c));
                    check_field("last", 64'(want.last), 64'(got.last));
                end
            end
            if (i_cfg_wr_en)
                depth_floor = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready)
                tally_read_beat(i_s_tdata, i_s_tlast, i_s_tuser);
        end
        o_pending <= expected_results.size();
        o_errors  <= fail_count;
    end

endmodule

// ----- sim/allele_pileup_fraction_estimator_unit_test.sv -----
module allele_pileup_fraction_estimator_unit_test;
    import apfe_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 120;
    localparam logic [7:0] ACGT [4] = '{BASE_A, BASE_C, BASE_G, BASE_T};

    typedef struct packed {
        logic [31:0] site_id;
        logic [7:0]  ref_b;
        logic [7:0]  alt_b;
        logic [7:0]  min_mq;
        logic [7:0]  min_bq;
    } t_site;

    typedef struct packed {
        t_site      site;
        logic       has_read;
        logic       dup;
        logic [7:0] mq;
        logic [7:0] bq;
        logic [7:0] ob;
        logic       site_end;
        logic       batch_end;
    } t_read_beat;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [15:0]            cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tlast     = 1'b0;
    logic [IN_TUSER_W-1:0]  s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [OUT_TUSER_W-1:0] m_tuser;
    int                     s_idle_pct  = 29;
    int                     m_idle_pct  = 81;
    int                     stall_cycles = 0;
    int                     error_count;
    int                     pending_results;

    allele_pileup_fraction_estimator_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tlast     (m_tlast),
        .o_m_tuser     (m_tuser)
    );

    allele_pileup_fraction_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tuser     (m_tuser),
        .o_errors      (error_count),
        .o_pending     (pending_results)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_read_beat read_at(input t_site st, input logic has, input logic dup,
                                           input logic [7:0] mq, input logic [7:0] bq,
                                           input logic [7:0] ob, input logic se,
                                           input logic be);
        t_read_beat b;
        b.site      = st;
        b.has_read  = has;
        b.dup       = dup;
        b.mq        = mq;
        b.bq        = bq;
        b.ob        = ob;
        b.site_end  = se;
        b.batch_end = be;
        return b;
    endfunction

    function automatic logic [7:0] random_base();
        return ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                        : ACGT[2'($urandom_range(3))];
    endfunction

    function automatic logic [7:0] random_floor();
        return ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
    endfunction

    // mostly at or just over the floor, sometimes one below or anywhere
    function automatic logic [7:0] near_floor(input logic [7:0] fl);
        case ($urandom_range(9))
            0, 1:    return 8'($urandom_range(255));
            2:       return fl - 8'd1;
            default: return fl + 8'($urandom_range(30));
        endcase
    endfunction

    function automatic t_site pick_site();
        t_site st;
        st.site_id = $urandom();
        st.ref_b   = random_base();
        st.alt_b   = random_base();
        st.min_mq  = random_floor();
        st.min_bq  = random_floor();
        return st;
    endfunction

    function automatic t_read_beat random_read(input t_site st);
        t_read_beat b;
        int         pick;
        b.site = st;
        // noise: a beat whose site fields stray from the rest of the site
        if ($urandom_range(19) == 0)
            b.site = pick_site();
        b.has_read = ($urandom_range(15) != 0);
        b.dup      = ($urandom_range(15) == 0);
        b.mq       = near_floor(b.site.min_mq);
        b.bq       = near_floor(b.site.min_bq);
        pick = $urandom_range(99);
        if (pick < 45)
            b.ob = b.site.ref_b;
        else if (pick < 70)
            b.ob = b.site.alt_b;
        else if (pick < 90)
            b.ob = ACGT[2'($urandom_range(3))];
        else
            b.ob = 8'($urandom_range(255));
        b.site_end  = 1'b0;
        b.batch_end = 1'b0;
        return b;
    endfunction

    task automatic push_beat(input t_read_beat b);
        logic [IN_TUSER_W-1:0] flags;
        flags = '0;
        flags[TU_HAS_READ]  = b.has_read;
        flags[TU_DUPLICATE] = b.dup;
        flags[TU_BATCH_END] = b.batch_end;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.ob, b.bq, b.mq, b.site.min_bq, b.site.min_mq,
                     b.site.alt_b, b.site.ref_b, b.site.site_id};
        s_tlast  <= b.site_end;
        s_tuser  <= flags;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // an item that closes nothing may still be in the pipe, so give it time
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_depth(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_sites(input int n_items, input int hold_at);
        t_site      st;
        t_read_beat b;
        int         sent;
        int         len;
        sent = 0;
        while (sent < n_items) begin
            st  = pick_site();
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 16);
            for (int k = 0; k < len; k++) begin
                b = random_read(st);
                b.site_end  = (k == len - 1);
                b.batch_end = b.site_end ? ($urandom_range(5) == 0) : ($urandom_range(59) == 0);
                push_beat(b);
                sent++;
                if (sent == hold_at)
                    wait_results();
            end
        end
    endtask

    initial begin : stimulus
        t_site      st0, st1, st2, st3, st4;
        t_read_beat flush;

        st0   = '{32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        flush = read_at(st0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero depth passes only with a zero floor
        write_min_depth(16'd0);
        push_beat(read_at(st0, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));

        st1 = '{32'hFFFF_FFFF, BASE_A, BASE_T, 8'd0, 8'd0};
        push_beat(read_at(st1, 1'b1, 1'b0, 8'd0, 8'd0, BASE_A, 1'b0, 1'b0));
        push_beat(read_at(st1, 1'b1, 1'b0, 8'd255, 8'd255, BASE_T, 1'b0, 1'b0));
        push_beat(read_at(st1, 1'b1, 1'b0, 8'd7, 8'd9, BASE_C, 1'b0, 1'b0));
        push_beat(read_at(st1, 1'b1, 1'b0, 8'd7, 8'd9, BASE_G, 1'b0, 1'b0));
        // lower-case a counts as nothing
        push_beat(read_at(st1, 1'b1, 1'b0, 8'd30, 8'd30, 8'h61, 1'b0, 1'b0));
        push_beat(read_at(st1, 1'b1, 1'b1, 8'd30, 8'd30, BASE_T, 1'b0, 1'b0));
        push_beat(read_at(st1, 1'b1, 1'b0, 8'd30, 8'd30, 8'h00, 1'b1, 1'b0));

        // ref equal to alt, floors at the top
        st2 = '{32'h8000_0001, BASE_G, BASE_G, 8'hFF, 8'hFF};
        push_beat(read_at(st2, 1'b1, 1'b0, 8'd255, 8'd255, BASE_G, 1'b0, 1'b0));
        push_beat(read_at(st2, 1'b1, 1'b0, 8'd254, 8'd255, BASE_G, 1'b0, 1'b0));
        push_beat(read_at(st2, 1'b1, 1'b0, 8'd255, 8'd254, BASE_G, 1'b0, 1'b0));
        push_beat(read_at(st2, 1'b1, 1'b0, 8'd255, 8'd255, BASE_T, 1'b0, 1'b0));
        push_beat(read_at(st2, 1'b0, 1'b0, 8'd255, 8'd255, BASE_G, 1'b1, 1'b1));
        push_beat(flush);
        settle();

        write_min_depth(16'd5);
        st3 = '{32'h1234_5678, BASE_T, BASE_C, 8'd10, 8'd10};
        push_beat(read_at(st3, 1'b1, 1'b0, 8'd40, 8'd40, BASE_T, 1'b0, 1'b0));
        push_beat(read_at(st3, 1'b1, 1'b0, 8'd40, 8'd40, BASE_C, 1'b1, 1'b0));
        // summary mid-site, then the open site carries on; other outweighs alt
        st4 = '{32'h0000_00A5, BASE_C, BASE_A, 8'd0, 8'd0};
        push_beat(read_at(st4, 1'b1, 1'b0, 8'd1, 8'd1, BASE_A, 1'b0, 1'b0));
        push_beat(read_at(st4, 1'b1, 1'b0, 8'd1, 8'd1, BASE_G, 1'b0, 1'b0));
        push_beat(read_at(st4, 1'b1, 1'b0, 8'd1, 8'd1, BASE_G, 1'b0, 1'b1));
        push_beat(read_at(st4, 1'b1, 1'b0, 8'd1, 8'd1, BASE_T, 1'b0, 1'b0));
        push_beat(read_at(st4, 1'b1, 1'b0, 8'd1, 8'd1, BASE_T, 1'b1, 1'b0));
        push_beat(flush);
        settle();

        write_min_depth(16'd6);
        run_random_sites(500, 250);
        push_beat(flush);
        settle();

        s_idle_pct = 81;
        m_idle_pct <= 29;
        write_min_depth(16'($urandom_range(1, 12)));
        run_random_sites(500, 0);
        push_beat(flush);
        settle();

        s_idle_pct = 0;
        m_idle_pct <= 0;
        write_min_depth(16'hFFFF);
        run_random_sites(200, 0);
        push_beat(flush);
        settle();

        write_min_depth(16'd0);
        run_random_sites(300, 0);
        push_beat(flush);
        settle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/apfe_pkg.sv
sv/apfe_div.sv
sv/apfe_ctrl.sv
sv/apfe_dp.sv
sv/allele_pileup_fraction_estimator_unit.sv
sim/allele_pileup_fraction_monitor.sv
sim/allele_pileup_fraction_estimator_unit_test.sv
